// ----- src/fdeq_pkg.sv -----
// ----------------------------------------------------------------------------
// fdeq_pkg
// shared constants and controller/datapath interface types for the
// frame delay event queue
// ----------------------------------------------------------------------------
package fdeq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // result kinds
  localparam logic [1:0] KIND_FIRED   = 2'd0;
  localparam logic [1:0] KIND_NONE    = 2'd1;
  localparam logic [1:0] KIND_SCHED   = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  // input command codes
  localparam logic CMD_SCHEDULE = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  typedef struct packed {
    logic       load;
    logic       insert;
    logic       pop;
    logic       advance;
    logic       push;
    logic [1:0] kind;
    logic       last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic head_due;
    logic next_due;
    logic full;
    logic out_free;
  } dp_status_t;

endpackage

// ----- src/fdeq_ctrl.sv -----
// ----------------------------------------------------------------------------
// fdeq_ctrl
// sequencer for schedule and tick transactions of the event queue
// ----------------------------------------------------------------------------
module fdeq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  fdeq_pkg::dp_status_t  status,
  output fdeq_pkg::ctrl_cmd_t   ctrl
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_INSERT = 3'b010,
    S_TICK   = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    ctrl         = '0;
    ctrl.kind    = fdeq_pkg::KIND_NONE;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = (cmd == fdeq_pkg::CMD_TICK) ? S_TICK : S_INSERT;
        end
      end
      S_INSERT: begin
        if (status.out_free) begin
          ctrl.push   = 1'b1;
          ctrl.last   = 1'b1;
          ctrl.kind   = status.full ? fdeq_pkg::KIND_REJECT : fdeq_pkg::KIND_SCHED;
          ctrl.insert = !status.full;
          state_next  = S_IDLE;
        end
      end
      S_TICK: begin
        if (status.out_free) begin
          ctrl.push = 1'b1;
          if (status.head_due) begin
            // one fired event per cycle while the result register is free, last when the next one is not due
            ctrl.kind = fdeq_pkg::KIND_FIRED;
            ctrl.pop  = 1'b1;
            ctrl.last = !status.next_due;
            if (!status.next_due) begin
              ctrl.advance = 1'b1;
              state_next   = S_IDLE;
            end
          end else begin
            ctrl.kind    = fdeq_pkg::KIND_NONE;
            ctrl.last    = 1'b1;
            ctrl.advance = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/fdeq_datapath.sv -----
// ----------------------------------------------------------------------------
// fdeq_datapath
// sorted entry chain, frame counter, item latch and result register
// ----------------------------------------------------------------------------
module fdeq_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [15:0]          delay_frames,
  input  logic [15:0]          event_tag,
  input  fdeq_pkg::ctrl_cmd_t  ctrl,
  output fdeq_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           kind,
  output logic [15:0]          fired_tag,
  output logic                 last
);

  localparam int D = fdeq_pkg::QUEUE_DEPTH;

  logic [15:0]                delay_q;
  logic [15:0]                tag_q;
  logic [31:0]                frame_count;
  logic [fdeq_pkg::CNT_W-1:0] entry_count;
  logic [31:0]                entry_due [D];
  logic [15:0]                entry_tag [D];
  logic [31:0]                new_due;
  logic [D-1:0]               le;
  logic [D-1:0]               prev_le;
  logic [31:0]                prev_due [D];
  logic [15:0]                prev_tag [D];
  logic [31:0]                up_due [D];
  logic [15:0]                up_tag [D];
  logic [31:0]                head_age;
  logic [31:0]                next_age;

  // item latch
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      delay_q <= delay_frames;
      tag_q   <= event_tag;
    end
  end

  assign new_due = frame_count + {16'b0, delay_q};

  // each cell compares its offset from the current frame with the new delay
  genvar g;
  generate
    for (g = 0; g < D; g++) begin : g_cell
      assign le[g] = (entry_count > fdeq_pkg::CNT_W'(g)) &&
                     ((entry_due[g] - frame_count) <= {16'b0, delay_q});
      if (g == 0) begin : g_first
        assign prev_le[g]  = 1'b0;
        assign prev_due[g] = new_due;
        assign prev_tag[g] = tag_q;
      end else begin : g_rest
        assign prev_le[g]  = le[g-1];
        assign prev_due[g] = entry_due[g-1];
        assign prev_tag[g] = entry_tag[g-1];
      end
      if (g == D - 1) begin : g_tail
        assign up_due[g] = entry_due[g];
        assign up_tag[g] = entry_tag[g];
      end else begin : g_body
        assign up_due[g] = entry_due[g+1];
        assign up_tag[g] = entry_tag[g+1];
      end

      always_ff @(posedge clk) begin
        if (ctrl.insert) begin
          if (!le[g]) begin
            if (g == 0 || prev_le[g]) begin
              entry_due[g] <= new_due;
              entry_tag[g] <= tag_q;
            end else begin
              entry_due[g] <= prev_due[g];
              entry_tag[g] <= prev_tag[g];
            end
          end
        end else if (ctrl.pop) begin
          entry_due[g] <= up_due[g];
          entry_tag[g] <= up_tag[g];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      frame_count <= '0;
    end else begin
      if (ctrl.insert) begin
        entry_count <= entry_count + fdeq_pkg::CNT_W'(1);
      end else if (ctrl.pop) begin
        entry_count <= entry_count - fdeq_pkg::CNT_W'(1);
      end
      if (ctrl.advance) begin
        frame_count <= frame_count + 32'd1;
      end
    end
  end

  // wrap-aware due test: reached when frame - due is below half range
  assign head_age = frame_count - entry_due[0];
  assign next_age = frame_count - entry_due[1];

  assign status.head_due = (entry_count != '0) && !head_age[31];
  assign status.next_due = (entry_count >= fdeq_pkg::CNT_W'(2)) && !next_age[31];
  assign status.full     = (entry_count == fdeq_pkg::CNT_W'(D));
  assign status.out_free = !out_valid || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      kind      <= ctrl.kind;
      last      <= ctrl.last;
      fired_tag <= (ctrl.kind == fdeq_pkg::KIND_FIRED) ? entry_tag[0] : 16'd0;
    end
  end

endmodule

// ----- src/frame_delay_event_queue.sv -----
// ----------------------------------------------------------------------------
// frame_delay_event_queue
// delayed-event queue ordered by due frame, with a 32-bit frame counter
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready): one transaction is a schedule
//   (cmd 0: delay_frames, event_tag) or a frame tick (cmd 1)
// output channel (out_valid/out_ready): kind, fired_tag, last
//   schedule -> one result, kind scheduled or rejected full
//   tick -> one fired result per due event, oldest due first, or a
//   single "none due" result; last marks the end of each transaction
// entries sit in a sorted register chain of QUEUE_DEPTH cells; a schedule
//   finds its place and shifts the tail in the same cycle, equal due frames
//   keep insertion order
// a schedule is accepted, then inserted with its result queued
// a tick is accepted, then does one chain pop per fired event
// one transaction is processed at a time; the next is accepted as soon
//   as the previous one has queued its last result
// the result register lets a new transaction be accepted while the
//   last result still waits; a stalled receiver holds the sequencer
// reset clears the frame counter, the fill count and the result valid
// ----------------------------------------------------------------------------
module frame_delay_event_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [15:0] delay_frames,
  input  logic [15:0] event_tag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] fired_tag,
  output logic        last
);

  fdeq_pkg::ctrl_cmd_t  ctrl;
  fdeq_pkg::dp_status_t status;

  // sequencer
  fdeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status),
    .ctrl     (ctrl)
  );

  // sorted chain, counters and result register
  fdeq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .delay_frames (delay_frames),
    .event_tag    (event_tag),
    .ctrl         (ctrl),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .fired_tag    (fired_tag),
    .last         (last)
  );

endmodule
